// ===== hdl/distance_vector_route_table_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the distance-vector route table core
// ---------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_CORE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define DVRT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DVRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dvrt_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dvrt_pkg
// Shared types, operation codes and helpers of the route table core.
// ---------------------------------------------------------------------------
package dvrt_pkg;

  localparam int ADDR_W = 32;
  localparam int PLEN_W = 6;
  localparam int DIST_W = 16;
  localparam int IDX_W  = 4;
  localparam int STAT_W = 2;
  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UNREACH = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_REACH   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOMATCH = 2'd2;

  localparam logic [DIST_W-1:0] INF_RESET = 16'hFFFF;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
    logic [PLEN_W-1:0] mask_len;
    logic [DIST_W-1:0] distance;
    logic [ADDR_W-1:0] next_hop;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DIST_W-1:0] found_distance;
    logic [IDX_W-1:0]  entry_index;
    logic              advertise;
  } rsp_t;

  typedef logic [DIST_W-1:0] cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] network;
    logic [PLEN_W-1:0] prefix;
    logic [DIST_W-1:0] distance;
    logic [ADDR_W-1:0] via;
    logic              direct;
    logic              advertise;
  } entry_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
    logic out_free;
  } stat_t;

  // top p bits set; p of 32 and above gives all ones
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] p);
    logic [ADDR_W-1:0] m;
    if (p >= PLEN_W'(ADDR_W)) begin
      m = '1;
    end else begin
      m = ~({ADDR_W{1'b1}} >> p);
    end
    return m;
  endfunction

endpackage

// ===== hdl/dvrt_chan_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dvrt_chan_if
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface dvrt_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/dvrt_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dvrt_ctrl
// Sequencer: accepts a request, drives the table scan, hands off the result.
// ---------------------------------------------------------------------------
module dvrt_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic [dvrt_pkg::FUNC_W-1:0]     req_func,
  input  dvrt_pkg::stat_t                 stat,
  output dvrt_pkg::cmd_t                  cmd,
  output logic                            req_ready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          if (req_func == dvrt_pkg::FUNC_INSERT || stat.empty) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/dvrt_datapath.sv =====
`timescale 1ns / 1ps
`include "distance_vector_route_table_core_defines.svh"
// ---------------------------------------------------------------------------
// dvrt_datapath
// Route memory, entry count, scan compare, hit tracking and result register.
// ---------------------------------------------------------------------------
module dvrt_datapath #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  dvrt_pkg::cmd_t  cmd,
  output dvrt_pkg::stat_t stat,
  input  dvrt_pkg::req_t  req_data,
  dvrt_chan_if.source     rsp,
  dvrt_chan_if.sink       cfg
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = dvrt_pkg::IDX_W;

  dvrt_pkg::entry_t mem [DEPTH];

  logic [CW-1:0]                 entry_count;
  logic [dvrt_pkg::DIST_W-1:0]   inf_dist;
  dvrt_pkg::req_t                req_q;
  logic [dvrt_pkg::ADDR_W-1:0]   req_mask;
  logic [AW-1:0]                 scan_idx;
  logic [AW-1:0]                 rd_idx;
  logic                          rd_valid;
  dvrt_pkg::entry_t              rd_entry;
  logic                          hit;
  logic [AW-1:0]                 hit_idx;
  dvrt_pkg::entry_t              hit_entry;
  logic                          rsp_valid;
  dvrt_pkg::rsp_t                rsp_q;
  dvrt_pkg::rsp_t                rsp_next;

  logic                          full;
  logic [dvrt_pkg::ADDR_W-1:0]   e_mask;
  logic                          contain;
  logic                          upd;
  logic                          match;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  dvrt_pkg::entry_t              wr_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inf_dist <= dvrt_pkg::INF_RESET;
    end else if (cfg.valid && cfg.ready) begin
      inf_dist <= cfg.data;
    end
  end

  assign full = (entry_count == CW'(DEPTH));

  assign stat.empty     = (entry_count == '0);
  assign stat.scan_last = ((CW'(scan_idx) + CW'(1)) == entry_count);
  assign stat.out_free  = !rsp_valid || rsp.ready;

  // request capture and scan address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q    <= req_data;
      req_mask <= dvrt_pkg::prefix_mask(req_data.mask_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
      if (cmd.load) begin
        scan_idx <= '0;
      end else if (cmd.issue) begin
        scan_idx <= scan_idx + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_entry <= mem[scan_idx];
      rd_idx   <= scan_idx;
    end
  end

  // per-entry compare
  assign e_mask  = dvrt_pkg::prefix_mask(rd_entry.prefix);
  assign contain = (((req_q.addr ^ rd_entry.network) & e_mask) == '0);
  assign upd     = (rd_entry.network == req_q.addr && rd_entry.prefix == req_q.mask_len) ||
                   (!rd_entry.direct && (((rd_entry.via ^ req_q.addr) & req_mask) == '0));
  assign match   = (req_q.func == dvrt_pkg::FUNC_UNREACH) ? upd : contain;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.load) begin
      hit <= 1'b0;
    end else if (rd_valid && match) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid && match) begin
      hit_idx   <= rd_idx;
      hit_entry <= rd_entry;
    end
  end

  // single write port
  always_comb begin
    wr_en            = 1'b0;
    wr_addr          = rd_idx;
    wr_data          = rd_entry;
    wr_data.distance = inf_dist;
    if (rd_valid && req_q.func == dvrt_pkg::FUNC_UNREACH && upd) begin
      wr_en = 1'b1;
    end
    if (cmd.finish) begin
      if (req_q.func == dvrt_pkg::FUNC_INSERT && !full) begin
        wr_en             = 1'b1;
        wr_addr           = AW'(entry_count);
        wr_data.network   = req_q.addr;
        wr_data.prefix    = req_q.mask_len;
        wr_data.distance  = req_q.distance;
        wr_data.via       = req_q.next_hop;
        wr_data.direct    = 1'b0;
        wr_data.advertise = 1'b1;
      end else if (req_q.func == dvrt_pkg::FUNC_REACH && hit) begin
        wr_en             = 1'b1;
        wr_addr           = hit_idx;
        wr_data           = hit_entry;
        wr_data.distance  = req_q.distance;
        wr_data.direct    = 1'b1;
        wr_data.advertise = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.finish && req_q.func == dvrt_pkg::FUNC_INSERT && !full) begin
      entry_count <= entry_count + CW'(1);
    end
  end

  // result
  always_comb begin
    rsp_next = '0;
    case (req_q.func)
      dvrt_pkg::FUNC_INSERT: begin
        if (full) begin
          rsp_next.status = dvrt_pkg::STAT_FULL;
        end else begin
          rsp_next.entry_index = IW'(entry_count);
        end
      end
      dvrt_pkg::FUNC_LOOKUP: begin
        if (hit) begin
          rsp_next.found_distance = hit_entry.distance;
          rsp_next.entry_index    = IW'(hit_idx);
          rsp_next.advertise      = hit_entry.advertise;
        end else begin
          rsp_next.status         = dvrt_pkg::STAT_NOMATCH;
          rsp_next.found_distance = inf_dist;
        end
      end
      dvrt_pkg::FUNC_UNREACH: begin
        if (hit) begin
          rsp_next.entry_index = IW'(hit_idx);
        end else begin
          rsp_next.status = dvrt_pkg::STAT_NOMATCH;
        end
      end
      dvrt_pkg::FUNC_REACH: begin
        if (hit) begin
          rsp_next.entry_index = IW'(hit_idx);
          rsp_next.advertise   = 1'b1;
        end else begin
          rsp_next.status = dvrt_pkg::STAT_NOMATCH;
        end
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_q;

  `DVRT_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, entry_count <= CW'(DEPTH), "entry count above depth")
  `DVRT_ASSERT_IMPL(a_read_in_range, clk, rst, cmd.issue, CW'(scan_idx) < entry_count, "scan past last entry")
  `DVRT_ASSERT_NEXT(a_insert_count, clk, rst, cmd.finish && req_q.func == dvrt_pkg::FUNC_INSERT && !full, entry_count == $past(entry_count) + CW'(1), "insert did not grow table")
  `DVRT_ASSERT_IMPL(a_finish_free, clk, rst, cmd.finish, !rsp_valid || rsp.ready, "result overwritten before taken")

endmodule

// ===== hdl/distance_vector_route_table_core.sv =====
// Insert, or any operation on an empty table: result registered from S_DONE once the
// output is free; next request taken after the return to S_IDLE.
// Lookup and marks: one table entry read per cycle from the route memory; result
// registered after S_SCAN, S_LAST and S_DONE; no new request taken before S_IDLE.
// Reset clears the entry count and sets infinity to 65535; route memory is not cleared.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// distance_vector_route_table_core
// Distance-vector route table: insert, lookup, mark unreachable, mark reachable.
// ---------------------------------------------------------------------------
module distance_vector_route_table_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  dvrt_chan_if.sink   req,
  dvrt_chan_if.source rsp,
  dvrt_chan_if.sink   cfg
);

  dvrt_pkg::cmd_t  cmd;
  dvrt_pkg::stat_t stat;
  logic            req_ready;

  assign req.ready = req_ready;

  dvrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.data.func),
    .stat      (stat),
    .cmd       (cmd),
    .req_ready (req_ready)
  );

  dvrt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .req_data (req.data),
    .rsp      (rsp),
    .cfg      (cfg)
  );

endmodule
